[design/scfr_pkg.sv]
package scfr_pkg;

	localparam int FrameBytes = 24;
	localparam int StageDepth = FrameBytes - 1;
	localparam int CrcLast    = 21;
	localparam int NumWords   = 5;
	localparam int ModeIdx    = CrcLast - 1;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	localparam int OutBits = 2 + NumWords * 32 + 8 + 2 + 2;
	localparam int OutTdataBits = ((OutBits + 7) / 8) * 8;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_LEN   = 2'd1,
		STATUS_BAD_START = 2'd2,
		STATUS_BAD_CRC   = 2'd3
	} status_t;

	typedef struct packed {
		status_t                     status;
		logic [NumWords-1:0][31:0]   words;
		logic [7:0]                  mode;
	} verdict_t;

	function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// value 3 decodes to 0
	function automatic logic [1:0] decode_mode(input logic [7:0] m);
		return (m[1:0] == 2'd3) ? 2'd0 : m[1:0];
	endfunction

endpackage

[design/scfr_assembler.sv]
module scfr_assembler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_en,
	input  logic                idle_en,
	input  logic [7:0]          data,
	input  logic [7:0]          start_byte,
	output scfr_pkg::verdict_t  verdict
);

	logic [7:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  first_q;
	logic [7:0]  stage_q [scfr_pkg::StageDepth];

	logic in_stage;
	logic in_crc;

	assign in_stage = (count_q >= 8'd1) && (count_q <= 8'(scfr_pkg::StageDepth));
	assign in_crc   = (count_q >= 8'd1) && (count_q <= 8'(scfr_pkg::CrcLast));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
			crc_q   <= scfr_pkg::CrcInit;
			first_q <= 8'd0;
		end else if (idle_en) begin
			count_q <= 8'd0;
			crc_q   <= scfr_pkg::CrcInit;
		end else if (byte_en) begin
			if (count_q == 8'd0) begin
				first_q <= data;
			end
			if (in_crc) begin
				crc_q <= scfr_pkg::crc_add_byte(crc_q, data);
			end
			if (count_q != 8'hFF) begin
				count_q <= count_q + 8'd1;
			end
		end
	end

	// bytes 1..23 shift in; after a full frame byte n sits at index n-1
	always_ff @(posedge clk) begin
		if (byte_en && in_stage) begin
			for (int i = 0; i < scfr_pkg::StageDepth - 1; i++) begin
				stage_q[i] <= stage_q[i+1];
			end
			stage_q[scfr_pkg::StageDepth-1] <= data;
		end
	end

	always_comb begin
		if (count_q != 8'(scfr_pkg::FrameBytes)) begin
			verdict.status = scfr_pkg::STATUS_BAD_LEN;
		end else if (first_q != start_byte) begin
			verdict.status = scfr_pkg::STATUS_BAD_START;
		end else if (stage_q[scfr_pkg::CrcLast] != crc_q[15:8] ||
		             stage_q[scfr_pkg::CrcLast+1] != crc_q[7:0]) begin
			verdict.status = scfr_pkg::STATUS_BAD_CRC;
		end else begin
			verdict.status = scfr_pkg::STATUS_OK;
		end
		for (int k = 0; k < scfr_pkg::NumWords; k++) begin
			verdict.words[k] = {stage_q[4*k+3], stage_q[4*k+2], stage_q[4*k+1], stage_q[4*k]};
		end
		verdict.mode = stage_q[scfr_pkg::ModeIdx];
	end

endmodule

[design/serial_command_frame_receiver.sv]
// an idle word passes through the input register, then its result is registered at the output
// throughput: one input word per cycle; data words give no result
// the input stalls only while a result is pending and the output is held
// reset (arst_n low, asynchronous) clears the byte count, crc, held setpoints,
// held mode and start byte; no result is pending after reset
module serial_command_frame_receiver (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [7:0]                            cfg_wdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [7:0]                            s_tdata,   // rx_byte
	input  logic                                  s_tuser,   // cmd
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// status, speed_x, speed_y, turn_rate, yaw_step, pitch_step, mode_byte,
	// chassis_mode, gimbal_mode, zero pad
	output logic [scfr_pkg::OutTdataBits-1:0]     m_tdata
);

	localparam int PadBits = scfr_pkg::OutTdataBits - scfr_pkg::OutBits;

	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  start_q;

	logic [scfr_pkg::NumWords-1:0][31:0] held_words_q;
	logic [7:0]                          held_mode_q;
	logic                                out_valid_q;
	logic [scfr_pkg::OutTdataBits-1:0]   out_data_q;

	logic advance;
	logic byte_en;
	logic idle_en;
	scfr_pkg::verdict_t verdict;

	logic [scfr_pkg::NumWords-1:0][31:0] words_next;
	logic [7:0]                          mode_next;

	assign advance  = valid_s1 && (!cmd_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign byte_en  = advance && !cmd_s1;
	assign idle_en  = advance && cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 8'd0;
		end else if (cfg_we) begin
			start_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	scfr_assembler u_asm (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (byte_en),
		.idle_en    (idle_en),
		.data       (byte_s1),
		.start_byte (start_q),
		.verdict    (verdict)
	);

	always_comb begin
		if (verdict.status == scfr_pkg::STATUS_OK) begin
			words_next = verdict.words;
			mode_next  = verdict.mode;
		end else begin
			words_next = held_words_q;
			mode_next  = held_mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_words_q <= '0;
			held_mode_q  <= 8'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (idle_en) begin
				held_words_q <= words_next;
				held_mode_q  <= mode_next;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (idle_en) begin
			out_data_q <= {{PadBits{1'b0}},
			               scfr_pkg::decode_mode(mode_next),
			               scfr_pkg::decode_mode(mode_next),
			               mode_next,
			               words_next,
			               verdict.status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[design/scfr_checker.sv]
module scfr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic                               s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [scfr_pkg::OutTdataBits-1:0]  m_tdata
);

	localparam int HeldLo = 2;
	localparam int HeldHi = 2 + scfr_pkg::NumWords * 32 + 8 - 1;

	logic [HeldHi:HeldLo] last_held_q;
	logic                 byte_seen;
	logic [1:0]           mode_dec;

	assign byte_seen = s_tvalid && s_tready && !s_tuser;
	assign mode_dec  = (m_tdata[HeldHi-6:HeldHi-7] == 2'd3) ? 2'd0 : m_tdata[HeldHi-6:HeldHi-7];

	// held setpoints as last delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_held_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_held_q <= m_tdata[HeldHi:HeldLo];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_mode_decode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[HeldHi+2:HeldHi+1] == mode_dec &&
		             m_tdata[HeldHi+4:HeldHi+3] == mode_dec)
		else $error("mode decode mismatch");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata[1:0] != 2'd0 |->
			m_tdata[HeldHi:HeldLo] == last_held_q)
		else $error("rejected frame changed held values");

	a_no_result_early: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("result present right after reset");

	// a data word never waits on the output side
	a_byte_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		byte_seen |=> s_tready)
		else $error("input stalled behind a data word");

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
